// ===== src/matern_pkg.sv =====
`timescale 1ns / 1ps
package matern_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DECAY_RATE     = 2'd0;
  localparam logic [1:0] REG_VARIANCE_SCALE = 2'd1;
  localparam logic [1:0] REG_TWICE_NU       = 2'd2;

  // smoothness codes
  localparam logic [2:0] NU_HALF         = 3'd1;
  localparam logic [2:0] NU_THREE_HALVES = 3'd3;
  localparam logic [2:0] NU_FIVE_HALVES  = 3'd5;

  localparam logic [31:0] DECAY_RESET = 32'h0001_0000;
  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

  // ln 2 in Q0.32 and floor(2^48 / ln2_q32) for the quotient estimate
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [16:0] LN2_RECIP = 17'(64'd281474976710656 / 64'd2977044472);
  // exact floor(x / 3) for x < 2^32 as (x * THIRD_RECIP) >> 33
  localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;

  localparam logic [47:0] H_LIMIT = 48'd48 << 16;
  localparam logic [29:0] P_ONE   = 30'h0001_0000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  localparam int SQRT_STEPS = 32;
  localparam int EXP_TERMS  = 14;

  typedef struct packed {
    logic       valid;
    logic [7:0] row;
    logic [7:0] col;
    logic       sat;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic        h_zero;
    logic        kill;
    logic [6:0]  k;
    logic [29:0] p;
  } exp_ctl_t;

  typedef struct packed {
    logic [31:0] covariance;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        sat;
  } rsp_t;

endpackage

// ===== src/matern_req_if.sv =====
`timescale 1ns / 1ps
interface matern_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         row_index;
  logic [7:0]         col_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;

  modport source (output valid, kind, row_index, col_index, coord_x, coord_y, input ready);
  modport sink   (input valid, kind, row_index, col_index, coord_x, coord_y, output ready);
endinterface

// ===== src/matern_rsp_if.sv =====
`timescale 1ns / 1ps
interface matern_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] covariance;
  logic [7:0]  out_row;
  logic [7:0]  out_col;
  logic        saturated;

  modport source (output valid, covariance, out_row, out_col, saturated, input ready);
  modport sink   (input valid, covariance, out_row, out_col, saturated, output ready);
endinterface

// ===== src/matern_half_integer_covariance_core.sv =====
`timescale 1ns / 1ps
// Matern covariance engine for half-integer smoothness (nu = 1/2, 3/2, 5/2).
//
// req carries two kinds of request. kind 0 loads point row_index with
// (coord_x, coord_y); it is written when accepted and yields no result. kind 1
// asks for the covariance between stored points row_index and col_index and
// yields one result on the result channel, with the indices echoed.
// Configuration (decay, scale, smoothness code) enters via cfg_write/cfg_index/
// cfg_data; the user must write only while the engine is idle (unenforced).
//
// Throughput: one request per cycle while the result buffer has a free slot.
// The path runs through the 32-cell square-root chain and the 14-term exp chain
// (two stages per term) plus the front and back arithmetic stages.
// A two-entry result buffer sits at the output; the whole pipeline advances
// while that buffer has a free slot, so a request is still accepted while one
// result waits. When the receiver stalls and both slots fill, req.ready drops
// and every stage holds.
// Reset clears all valid flags and the result buffer and restores the
// register defaults (decay 1.0, scale 1.0, smoothness code 1). The point store
// is not cleared: only loaded points may be read.
module matern_half_integer_covariance_core #(
  parameter int COORD_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  matern_req_if.sink          req,
  matern_rsp_if.source        result,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  localparam int AW = $clog2(COORD_DEPTH);

  // ---------------- configuration registers ----------------
  logic [31:0] decay_rate;
  logic [31:0] variance_scale;
  logic [2:0]  twice_nu;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate     <= matern_pkg::DECAY_RESET;
      variance_scale <= matern_pkg::SCALE_RESET;
      twice_nu       <= matern_pkg::NU_HALF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        matern_pkg::REG_DECAY_RATE:     decay_rate     <= cfg_data;
        matern_pkg::REG_VARIANCE_SCALE: variance_scale <= cfg_data;
        matern_pkg::REG_TWICE_NU:       twice_nu       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // ---------------- result buffer and global advance ----------------
  matern_pkg::rsp_t fifo_data [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       cnt;
  logic             en;
  logic             push;
  logic             pop;
  matern_pkg::rsp_t push_data;

  // advance every stage while the buffer has room
  assign en        = (cnt != 2'd2);
  assign req.ready = en;

  // ---------------- point store ----------------
  logic [63:0]      coord_mem [COORD_DEPTH];
  logic [31:0]      row_wide;
  logic [31:0]      col_wide;
  logic [AW-1:0]    row_addr;
  logic [AW-1:0]    col_addr;
  logic             row_ok;
  logic             col_ok;
  logic             accept;

  always_comb begin
    row_wide = 32'(req.row_index);
    col_wide = 32'(req.col_index);
    row_addr = row_wide[AW-1:0];
    col_addr = col_wide[AW-1:0];
    row_ok   = (row_wide < 32'(COORD_DEPTH));
    col_ok   = (col_wide < 32'(COORD_DEPTH));
    accept   = req.valid && en;
  end

  // drop loads that point beyond the store
  always_ff @(posedge clk) begin
    if (accept && !req.kind && row_ok) begin
      coord_mem[row_addr] <= {req.coord_y, req.coord_x};
    end
  end

  logic [63:0]      rd_a;
  logic [63:0]      rd_b;
  logic             a_ok;
  logic             b_ok;
  matern_pkg::tag_t a_tag;

  always_ff @(posedge clk) begin
    if (en) begin
      rd_a <= coord_mem[row_addr];
      rd_b <= coord_mem[col_addr];
      a_ok <= row_ok;
      b_ok <= col_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
    end else if (en) begin
      a_tag.valid <= accept && req.kind;
      a_tag.row   <= req.row_index;
      a_tag.col   <= req.col_index;
      a_tag.sat   <= 1'b0;
    end
  end

  // ---------------- absolute differences ----------------
  logic [31:0]        xa, xb, ya, yb;
  logic signed [32:0] dx_s, dy_s;
  logic [32:0]        dx_abs, dy_abs;
  logic [31:0]        b_dx, b_dy;
  matern_pkg::tag_t   b_tag;

  always_comb begin
    // points beyond the store read as the origin
    xa     = a_ok ? rd_a[31:0]  : 32'd0;
    ya     = a_ok ? rd_a[63:32] : 32'd0;
    xb     = b_ok ? rd_b[31:0]  : 32'd0;
    yb     = b_ok ? rd_b[63:32] : 32'd0;
    dx_s   = $signed({xa[31], xa}) - $signed({xb[31], xb});
    dy_s   = $signed({ya[31], ya}) - $signed({yb[31], yb});
    dx_abs = dx_s[32] ? 33'(-dx_s) : 33'(dx_s);
    dy_abs = dy_s[32] ? 33'(-dy_s) : 33'(dy_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag <= '0;
    end else if (en) begin
      b_tag <= a_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_dx <= dx_abs[31:0];
      b_dy <= dy_abs[31:0];
    end
  end

  // ---------------- squares ----------------
  logic [63:0]      c_sx, c_sy;
  matern_pkg::tag_t c_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_tag <= '0;
    end else if (en) begin
      c_tag <= b_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sx <= 64'(b_dx) * 64'(b_dx);
      c_sy <= 64'(b_dy) * 64'(b_dy);
    end
  end

  // ---------------- sum and square-root chain ----------------
  matern_pkg::tag_t sq_tag  [matern_pkg::SQRT_STEPS + 1];
  logic [63:0]      sq_rad  [matern_pkg::SQRT_STEPS + 1];
  logic [33:0]      sq_rem  [matern_pkg::SQRT_STEPS + 1];
  logic [31:0]      sq_root [matern_pkg::SQRT_STEPS + 1];
  logic [64:0]      s_sum;

  assign s_sum = {1'b0, c_sx} + {1'b0, c_sy};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_tag[0] <= '0;
    end else if (en) begin
      // flag a radicand that does not fit in 64 bits
      sq_tag[0] <= '{valid: c_tag.valid, row: c_tag.row, col: c_tag.col, sat: s_sum[64]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad[0]  <= s_sum[63:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar i = 0; i < matern_pkg::SQRT_STEPS; i++) begin : g_sqrt
    matern_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .tag_in   (sq_tag[i]),
      .rad_in   (sq_rad[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .tag_out  (sq_tag[i+1]),
      .rad_out  (sq_rad[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
  end

  // ---------------- h = distance * decay ----------------
  logic [31:0]      root_dist;
  logic [63:0]      h_prod;
  logic [47:0]      e_h;
  matern_pkg::tag_t e_tag;

  always_comb begin
    root_dist = sq_tag[matern_pkg::SQRT_STEPS].sat ? 32'hFFFF_FFFF
                                                    : sq_root[matern_pkg::SQRT_STEPS];
    h_prod    = 64'(root_dist) * 64'(decay_rate);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_tag <= '0;
    end else if (en) begin
      e_tag <= sq_tag[matern_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_h <= h_prod[63:16];
    end
  end

  // ---------------- quotient estimate and h squared ----------------
  logic [38:0]      k_prod;
  logic [43:0]      hh_prod;
  logic [21:0]      f_hn;
  logic [6:0]       f_kest;
  logic [43:0]      f_hh;
  logic             f_hzero;
  logic             f_far;
  matern_pkg::tag_t f_tag;

  always_comb begin
    k_prod  = 39'(e_h[21:0]) * 39'(matern_pkg::LN2_RECIP);
    hh_prod = 44'(e_h[21:0]) * 44'(e_h[21:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_tag <= '0;
    end else if (en) begin
      f_tag <= e_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_hn    <= e_h[21:0];
      f_kest  <= k_prod[38:32];
      f_hh    <= hh_prod;
      f_hzero <= (e_h == 48'd0);
      f_far   <= (e_h >= matern_pkg::H_LIMIT);
    end
  end

  // ---------------- trial remainder and h*h/3 ----------------
  logic [38:0]      kl_prod;
  logic [37:0]      r_wide;
  logic [59:0]      q3_prod;
  logic [32:0]      g_r0;
  logic [26:0]      g_q3;
  logic [21:0]      g_hn;
  logic [6:0]       g_kest;
  logic             g_hzero;
  logic             g_far;
  matern_pkg::tag_t g_tag;

  always_comb begin
    kl_prod = 39'(f_kest) * 39'(matern_pkg::LN2_Q32);
    r_wide  = {f_hn, 16'h0000} - kl_prod[37:0];
    q3_prod = 60'(f_hh[43:16]) * 60'(matern_pkg::THIRD_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_tag <= '0;
    end else if (en) begin
      g_tag <= f_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r0    <= r_wide[32:0];
      g_q3    <= q3_prod[59:33];
      g_hn    <= f_hn;
      g_kest  <= f_kest;
      g_hzero <= f_hzero;
      g_far   <= f_far;
    end
  end

  // ---------------- correct quotient, build polynomial ----------------
  matern_pkg::exp_ctl_t ex_ctl [matern_pkg::EXP_TERMS + 1];
  logic [31:0]          ex_r   [matern_pkg::EXP_TERMS + 1];
  logic [32:0]          ex_t   [matern_pkg::EXP_TERMS + 1];
  logic signed [34:0]   ex_sum [matern_pkg::EXP_TERMS + 1];
  matern_pkg::exp_ctl_t h_ctl;
  logic                 corr;
  logic [32:0]          r_fix;
  logic                 nu_ok;

  always_comb begin
    corr  = (g_r0 >= 33'(matern_pkg::LN2_Q32));
    r_fix = corr ? (g_r0 - 33'(matern_pkg::LN2_Q32)) : g_r0;
    nu_ok = (twice_nu == matern_pkg::NU_HALF) ||
            (twice_nu == matern_pkg::NU_THREE_HALVES) ||
            (twice_nu == matern_pkg::NU_FIVE_HALVES);
    h_ctl.tag    = g_tag;
    h_ctl.h_zero = g_hzero;
    h_ctl.kill   = g_far || !nu_ok;
    h_ctl.k      = g_kest + 7'(corr);
    unique case (twice_nu)
      matern_pkg::NU_THREE_HALVES: h_ctl.p = matern_pkg::P_ONE + 30'(g_hn);
      matern_pkg::NU_FIVE_HALVES:  h_ctl.p = matern_pkg::P_ONE + 30'(g_hn) + 30'(g_q3);
      default:                     h_ctl.p = matern_pkg::P_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_ctl[0] <= '0;
    end else if (en) begin
      ex_ctl[0] <= h_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r[0]   <= r_fix[31:0];
      ex_t[0]   <= matern_pkg::ONE_Q32;
      ex_sum[0] <= $signed({2'b00, matern_pkg::ONE_Q32});
    end
  end

  for (genvar j = 0; j < matern_pkg::EXP_TERMS; j++) begin : g_exp
    matern_exp_cell #(
      .TERM (j + 1)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ex_ctl[j]),
      .r_in    (ex_r[j]),
      .t_in    (ex_t[j]),
      .sum_in  (ex_sum[j]),
      .ctl_out (ex_ctl[j+1]),
      .r_out   (ex_r[j+1]),
      .t_out   (ex_t[j+1]),
      .sum_out (ex_sum[j+1])
    );
  end

  // ---------------- p * exp(-r) ----------------
  logic [32:0]          e_val;
  logic [62:0]          pe_prod;
  logic [62:0]          i_prod;
  matern_pkg::exp_ctl_t i_ctl;

  always_comb begin
    e_val   = ex_sum[matern_pkg::EXP_TERMS][34] ? 33'd0
                                                 : ex_sum[matern_pkg::EXP_TERMS][32:0];
    pe_prod = 63'(ex_ctl[matern_pkg::EXP_TERMS].p) * 63'(e_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_ctl <= '0;
    end else if (en) begin
      i_ctl <= ex_ctl[matern_pkg::EXP_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_prod <= pe_prod;
    end
  end

  // ---------------- scale by 2^-(16+k), clamp to 1.0 ----------------
  logic [7:0]           sh;
  logic [62:0]          shifted;
  logic [32:0]          factor;
  logic [32:0]          j_factor;
  matern_pkg::exp_ctl_t j_ctl;

  always_comb begin
    sh      = 8'd16 + 8'(i_ctl.k);
    shifted = (sh >= 8'd64) ? 63'd0 : (i_prod >> sh[5:0]);
    factor  = (shifted > 63'(matern_pkg::ONE_Q32)) ? matern_pkg::ONE_Q32 : shifted[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_ctl <= '0;
    end else if (en) begin
      j_ctl <= i_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_factor <= factor;
    end
  end

  // ---------------- final product into the result buffer ----------------
  logic [64:0] cov_prod;

  always_comb begin
    cov_prod       = 65'(variance_scale) * 65'(j_factor);
    push_data.row  = j_ctl.tag.row;
    push_data.col  = j_ctl.tag.col;
    push_data.sat  = j_ctl.tag.sat;
    // h of zero returns the scale itself, else far or unsupported gives zero
    priority if (j_ctl.h_zero) begin
      push_data.covariance = variance_scale;
    end else if (j_ctl.kill) begin
      push_data.covariance = 32'd0;
    end else begin
      push_data.covariance = cov_prod[63:32];
    end
    push = en && j_ctl.tag.valid;
    pop  = result.valid && result.ready;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_data[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assign result.valid      = (cnt != 2'd0);
  assign result.covariance = fifo_data[rd_ptr].covariance;
  assign result.out_row    = fifo_data[rd_ptr].row;
  assign result.out_col    = fifo_data[rd_ptr].col;
  assign result.saturated  = fifo_data[rd_ptr].sat;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result buffer count out of range");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !req.ready)
    else $error("request accepted with full result buffer");
  a_load_no_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && !req.kind) |=> !a_tag.valid)
    else $error("load request entered the pipeline");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(j_ctl))
    else $error("pipeline moved during stall");
`endif
endmodule

// ===== src/matern_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One root bit per cell: bring down two radicand bits, try root*4+1.
module matern_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  matern_pkg::tag_t   tag_in,
  input  logic [63:0]        rad_in,
  input  logic [33:0]        rem_in,
  input  logic [31:0]        root_in,
  output matern_pkg::tag_t   tag_out,
  output logic [63:0]        rad_out,
  output logic [33:0]        rem_out,
  output logic [31:0]        root_out
);
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        take;

  always_comb begin
    rem_sh = {rem_in, rad_in[63:62]};
    trial  = {2'b00, root_in, 2'b01};
    diff   = rem_sh - trial;
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (en) begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[61:0], 2'b00};
      rem_out  <= take ? diff[33:0] : rem_sh[33:0];
      root_out <= {root_in[30:0], take};
    end
  end
endmodule

// ===== src/matern_exp_cell.sv =====
`timescale 1ns / 1ps
// One Taylor term of exp(-r): t = ((t * r) >> 32) / TERM, then add or subtract.
module matern_exp_cell #(
  parameter int TERM = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  matern_pkg::exp_ctl_t  ctl_in,
  input  logic [31:0]           r_in,
  input  logic [32:0]           t_in,
  input  logic signed [34:0]    sum_in,
  output matern_pkg::exp_ctl_t  ctl_out,
  output logic [31:0]           r_out,
  output logic [32:0]           t_out,
  output logic signed [34:0]    sum_out
);
  localparam int          SHIFT = $clog2(TERM);
  localparam logic [63:0] NUM   = 64'd1 << (32 + SHIFT);
  localparam logic [32:0] MULT  = 33'((NUM + 64'(TERM) - 64'd1) / 64'(TERM));

  matern_pkg::exp_ctl_t ctl_mid;
  logic [31:0]          r_mid;
  logic signed [34:0]   sum_mid;
  logic [31:0]          x_mid;
  logic [64:0]          tr_prod;
  logic [64:0]          q_prod;
  logic [64:0]          q_shift;
  logic [31:0]          q;

  always_comb begin
    tr_prod = 65'(t_in) * 65'(r_in);
    q_prod  = 65'(x_mid) * 65'(MULT);
    q_shift = q_prod >> (32 + SHIFT);
    q       = q_shift[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mid <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_mid <= ctl_in;
      ctl_out <= ctl_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_mid   <= tr_prod[63:32];
      r_mid   <= r_in;
      sum_mid <= sum_in;
      r_out   <= r_mid;
      t_out   <= {1'b0, q};
      if ((TERM % 2) == 1) begin
        sum_out <= sum_mid - $signed({3'b000, q});
      end else begin
        sum_out <= sum_mid + $signed({3'b000, q});
      end
    end
  end
endmodule

// ===== bench/matern_cov_checker.sv =====
`timescale 1ns / 1ps
module matern_cov_checker (
  input  logic         clk,
  input  logic         rst,
  matern_req_if        req,
  matern_rsp_if        result,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           outstanding,
  output int           checked,
  output int           sat_seen
);
  localparam longint unsigned FAR_H = 64'd48 << 16;

  logic [63:0]      point_mem [256];
  logic [31:0]      decay_q, scale_q;
  logic [2:0]       nu_q;
  matern_pkg::rsp_t cov_expected_q [$];

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  // exp(-r) for r in [0, ln 2), Q0.32
  function automatic longint unsigned exp_neg(longint unsigned r);
    longint sum;
    longint unsigned t;
    sum = 64'sd4294967296;
    t = 64'd4294967296;
    for (int i = 1; i <= matern_pkg::EXP_TERMS; i++) begin
      t = ((t * r) >> 32) / longint'(i);
      if (i % 2 == 1) sum -= longint'(t);
      else sum += longint'(t);
    end
    return (sum < 0) ? 0 : longint'(sum);
  endfunction

  function automatic longint unsigned shape_factor(longint unsigned h);
    longint unsigned poly, hs, k, r, prod, sh;
    if (h >= FAR_H) return 0;
    case (nu_q)
      matern_pkg::NU_HALF:         poly = 64'd65536;
      matern_pkg::NU_THREE_HALVES: poly = 64'd65536 + h;
      matern_pkg::NU_FIVE_HALVES:  poly = 64'd65536 + h + ((h * h) >> 16) / 3;
      default:                     return 0;
    endcase
    hs = h << 16;
    k = hs / longint'(matern_pkg::LN2_Q32);
    r = hs - k * longint'(matern_pkg::LN2_Q32);
    prod = poly * exp_neg(r);
    sh = 16 + k;
    if (sh >= 64) return 0;
    prod >>= sh;
    return (prod > 64'd4294967296) ? 64'd4294967296 : prod;
  endfunction

  function automatic longint unsigned abs_gap(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return (d < 0) ? longint'(-d) : longint'(d);
  endfunction

  function automatic matern_pkg::rsp_t covariance_of(logic [7:0] row, logic [7:0] col);
    matern_pkg::rsp_t o;
    longint unsigned dx, dy, root_dist, h, cov;
    logic [64:0] ssum;
    o.sat = 1'b0;
    dx = abs_gap(point_mem[row][31:0], point_mem[col][31:0]);
    dy = abs_gap(point_mem[row][63:32], point_mem[col][63:32]);
    ssum = {1'b0, dx * dx} + {1'b0, dy * dy};
    if (ssum[64]) begin
      root_dist = 64'hFFFF_FFFF;
      o.sat = 1'b1;
    end else begin
      root_dist = isqrt(ssum[63:0]);
    end
    h = (root_dist * longint'(decay_q)) >> 16;
    if (h == 0) cov = 64'(scale_q);
    else cov = (longint'(scale_q) * shape_factor(h)) >> 32;
    if (cov > 64'hFFFF_FFFF) begin
      cov = 64'hFFFF_FFFF;
      o.sat = 1'b1;
    end
    o.covariance = cov[31:0];
    o.row = row;
    o.col = col;
    return o;
  endfunction

  initial begin
    errors = 0;
    checked = 0;
    sat_seen = 0;
  end

  assign outstanding = cov_expected_q.size();

  always @(posedge clk) begin
    matern_pkg::rsp_t want;
    if (rst) begin
      decay_q <= matern_pkg::DECAY_RESET;
      scale_q <= matern_pkg::SCALE_RESET;
      nu_q    <= matern_pkg::NU_HALF;
      cov_expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          matern_pkg::REG_DECAY_RATE:     decay_q <= cfg_data;
          matern_pkg::REG_VARIANCE_SCALE: scale_q <= cfg_data;
          matern_pkg::REG_TWICE_NU:       nu_q    <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (!req.kind) point_mem[req.row_index] = {req.coord_y, req.coord_x};
        else cov_expected_q.push_back(covariance_of(req.row_index, req.col_index));
      end
      if (result.valid && result.ready) begin
        if (cov_expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result cov=%h row=%0d col=%0d sat=%b", $time,
                   result.covariance, result.out_row, result.out_col, result.saturated);
        end else begin
          want = cov_expected_q.pop_front();
          checked++;
          if (want.sat) sat_seen++;
          if (result.covariance !== want.covariance || result.out_row !== want.row ||
              result.out_col !== want.col || result.saturated !== want.sat) begin
            errors++;
            $display("%0t: mismatch expected cov=%h row=%0d col=%0d sat=%b", $time,
                     want.covariance, want.row, want.col, want.sat);
            $display("%0t:          actual   cov=%h row=%0d col=%0d sat=%b", $time,
                     result.covariance, result.out_row, result.out_col, result.saturated);
          end
        end
      end
    end
  end
endmodule

// ===== bench/matern_half_integer_covariance_core_tb.sv =====
`timescale 1ns / 1ps
module matern_half_integer_covariance_core_tb;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 180;
  // leave headroom for the pipeline to settle before touching registers
  localparam int SETTLE = 100;

  logic        clk, rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors, outstanding, checked, sat_seen;
  int          src_idle_pct, rcv_idle_pct;
  int          requests_sent, loads_sent;
  logic        loaded [256];

  matern_req_if req_ch ();
  matern_rsp_if rsp_ch ();

  // register settings per phase, extremes included
  logic [31:0] decay_set [PHASES] = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                                      32'h0000_4000, 32'h0003_0000, 32'h0000_0001,
                                      32'h0000_8000, 32'h0002_0000, 32'h0001_0000};
  logic [31:0] scale_set [PHASES] = '{32'hFFFF_FFFF, 32'h0002_0000, 32'h0000_0000,
                                      32'h1234_5678, 32'h0001_0000, 32'hFFFF_FFFF,
                                      32'h8000_0000, 32'h0000_0001, 32'h00A5_5A00};
  logic [2:0]  nu_set [PHASES] = '{matern_pkg::NU_THREE_HALVES, matern_pkg::NU_FIVE_HALVES,
                                   matern_pkg::NU_HALF, 3'd0, matern_pkg::NU_FIVE_HALVES,
                                   3'd7, matern_pkg::NU_THREE_HALVES, 3'd2, 3'd6};

  matern_half_integer_covariance_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .result    (rsp_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  matern_cov_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .result      (rsp_ch),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .sat_seen    (sat_seen)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // receiver: stall at the rate of the current idling mode
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // hand one request to the block; valid stays high for a following request
  task automatic send_request(logic kind, logic [7:0] row, logic [7:0] col,
                              logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.row_index <= row;
    req_ch.col_index <= col;
    req_ch.coord_x   <= x;
    req_ch.coord_y   <= y;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    requests_sent++;
    if (!kind) begin
      loaded[row] = 1'b1;
      loads_sent++;
    end
  endtask

  task automatic load_point(logic [7:0] idx, logic [31:0] x, logic [31:0] y);
    send_request(1'b0, idx, 8'($urandom), x, y);
  endtask

  task automatic ask_pair(logic [7:0] row, logic [7:0] col);
    send_request(1'b1, row, col, $urandom, $urandom);
  endtask

  // drain: hold until every result is back, then let the pipeline settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(32'h0010_0000) - 32'h0008_0000);
    endcase
  endfunction

  function automatic logic [7:0] pick_loaded();
    logic [7:0] idx;
    idx = 8'($urandom);
    while (!loaded[idx]) idx = 8'($urandom);
    return idx;
  endfunction

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = matern_pkg::REG_DECAY_RATE;
    cfg_data = '0;
    src_idle_pct = 35;
    rcv_idle_pct = 54;
    requests_sent = 0;
    loads_sent = 0;
    req_ch.valid = 1'b0;
    req_ch.kind = 1'b0;
    req_ch.row_index = '0;
    req_ch.col_index = '0;
    req_ch.coord_x = '0;
    req_ch.coord_y = '0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, edge coordinates, zero distance, distance
    // overflow, far points, nearby points
    load_point(8'd0, 32'h0000_0000, 32'h0000_0000);
    load_point(8'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    load_point(8'd2, 32'h8000_0000, 32'h8000_0000);
    load_point(8'd3, 32'h0001_0000, 32'h0000_0000);
    load_point(8'd4, 32'h0000_0000, 32'h0002_0000);
    load_point(8'd255, 32'hFFFF_8000, 32'h0000_4000);
    load_point(8'd170, 32'h0040_0000, 32'hFFC0_0000);
    ask_pair(8'd0, 8'd0);
    ask_pair(8'd1, 8'd1);
    ask_pair(8'd1, 8'd2);
    ask_pair(8'd2, 8'd1);
    ask_pair(8'd0, 8'd3);
    ask_pair(8'd0, 8'd4);
    ask_pair(8'd3, 8'd4);
    ask_pair(8'd0, 8'd1);
    ask_pair(8'd255, 8'd3);
    ask_pair(8'd170, 8'd0);
    ask_pair(8'd3, 8'd255);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      // idling mode: receiver-heavy, then sender-heavy, then none
      if (ph < 3) begin
        src_idle_pct = 35;
        rcv_idle_pct = 54;
      end else if (ph < 6) begin
        src_idle_pct = 54;
        rcv_idle_pct = 35;
      end else begin
        src_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_reg(matern_pkg::REG_DECAY_RATE, decay_set[ph]);
      write_reg(matern_pkg::REG_VARIANCE_SCALE, scale_set[ph]);
      write_reg(matern_pkg::REG_TWICE_NU, {29'd0, nu_set[ph]});
      cfg_write <= 1'b0;
      ask_pair(8'd0, 8'd3);
      ask_pair(8'd1, 8'd2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 22) load_point(8'($urandom), pick_coord(), pick_coord());
        else ask_pair(pick_loaded(), pick_loaded());
      end
      drain();
    end

    $display("Sent %0d requests (%0d point loads) over %0d register settings.",
             requests_sent, loads_sent, PHASES + 1);
    $display("Checked %0d covariance results, %0d with the saturation flag.",
             checked, sat_seen);
    if (errors == 0) begin
      $display("matern_half_integer_covariance_core test passed");
    end else begin
      $display("matern_half_integer_covariance_core test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("matern_half_integer_covariance_core test failed");
    $finish;
  end
endmodule
